>>> sv/ppc_pkg.sv
// Package for the polar pose controller: configuration, queue entry and
// pipeline stage types, register indexes, CORDIC angle table and step functions.
// Depends on nothing; every other file of the block but ppc_checker imports it.
package ppc_pkg;

    localparam int POS_W    = 16;
    localparam int DIFF_W   = 17;
    localparam int CW       = 28;
    localparam int SQW      = 32;
    localparam int NW       = 34;
    localparam int RHO_W    = 17;
    localparam int VEL_W    = 24;
    localparam int SQ_STEPS = 17;
    localparam int ANGLE_LEN = 24;
    localparam int CFG_AW   = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam logic [CFG_AW-1:0] REG_GAIN_DISTANCE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_ALPHA    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_BETA     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GOAL_X        = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GOAL_Y        = 3'd4;
    localparam logic [CFG_AW-1:0] REG_GOAL_HEADING  = 3'd5;

    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

    localparam logic [31:0] ATAN_LUT [ANGLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [POS_W-1:0] gain_distance;
        logic [POS_W-1:0] gain_alpha;
        logic [POS_W-1:0] gain_beta;
        logic [POS_W-1:0] goal_x;
        logic [POS_W-1:0] goal_y;
        logic [POS_W-1:0] goal_heading;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_distance: 16'd1280,
        gain_alpha:    16'd1408,
        gain_beta:     16'hFF73,
        goal_x:        16'd0,
        goal_y:        16'd0,
        goal_heading:  16'd0
    };

    typedef struct packed {
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        logic [POS_W-1:0]  ph;
        logic              flip;
        logic              at_goal;
    } t_item;

    typedef struct packed {
        logic [CW-1:0]    cx;
        logic [CW-1:0]    cy;
        logic [31:0]      z;
        logic [SQW-1:0]   sqx;
        logic [SQW-1:0]   sqy;
        logic [NW-1:0]    rem;
        logic [NW-1:0]    root;
        logic [POS_W-1:0] ph;
        logic             at_goal;
    } t_core;

    typedef struct packed {
        logic [33:0]      vel_p;
        logic [31:0]      st_a;
        logic [31:0]      st_b;
        logic [RHO_W-1:0] rho;
    } t_post;

    function automatic t_core cordic_step(t_core c, logic [4:0] i);
        t_core r;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        r  = c;
        sx = $signed(c.cx) >>> i;
        sy = $signed(c.cy) >>> i;
        if ($signed(c.cy) > 0) begin
            r.cx = CW'($signed(c.cx) + sy);
            r.cy = CW'($signed(c.cy) - sx);
            r.z  = c.z + ATAN_LUT[i];
        end else begin
            r.cx = CW'($signed(c.cx) - sy);
            r.cy = CW'($signed(c.cy) + sx);
            r.z  = c.z - ATAN_LUT[i];
        end
        return r;
    endfunction

    function automatic t_core sqrt_step(t_core c, logic [4:0] j);
        t_core r;
        logic [5:0]    sh;
        logic [NW-1:0] bitv;
        logic [NW-1:0] trial;
        r     = c;
        sh    = 6'(2 * (SQ_STEPS - 1)) - {j, 1'b0};
        bitv  = NW'(1) << sh;
        trial = c.root + bitv;
        if (c.rem >= trial) begin
            r.rem  = c.rem - trial;
            r.root = (c.root >> 1) + bitv;
        end else begin
            r.root = c.root >> 1;
        end
        return r;
    endfunction

endpackage

>>> sv/ppc_front.sv
// Front end: accepts pose beats, forms the goal offsets and classifies them
// (left half-plane, pose at goal) for the queue. Depends on ppc_pkg.
module ppc_front (
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [15:0]          i_pose_x,
    input  logic signed [15:0]          i_pose_y,
    input  logic signed [15:0]          i_pose_heading,
    input  ppc_pkg::t_cfg               i_cfg,
    input  logic                        i_q_full,
    output logic                        o_push,
    output ppc_pkg::t_item              o_item
);
    import ppc_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;

    assign dx = DIFF_W'($signed(i_cfg.goal_x)) - DIFF_W'(i_pose_x);
    assign dy = DIFF_W'($signed(i_cfg.goal_y)) - DIFF_W'(i_pose_y);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.dx      = dx;
        o_item.dy      = dy;
        o_item.ph      = i_pose_heading;
        o_item.flip    = dx < 0;
        o_item.at_goal = (dx == '0) && (dy == '0);
    end

endmodule

>>> sv/ppc_queue.sv
// Short queue of classified pose beats between front end and back end.
// Depends on ppc_pkg for the entry type and depth.
module ppc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ppc_pkg::t_item o_item
);
    import ppc_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;

    assign o_full  = r_count == (Q_AW + 1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/ppc_back.sv
// Back end: pipelined CORDIC bearing, pipelined square root, gain products,
// shift and saturation, and the output register. Depends on ppc_pkg.
module ppc_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppc_pkg::t_cfg               i_cfg,
    input  logic                        i_q_empty,
    input  ppc_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [23:0]          o_velocity,
    output logic signed [15:0]          o_steering,
    output logic [16:0]                 o_distance
);
    import ppc_pkg::*;

    localparam int SE = (CORDIC_STEPS > ANGLE_LEN) ? ANGLE_LEN : CORDIC_STEPS;
    localparam int LC = (SE > SQ_STEPS + 1) ? SE : SQ_STEPS + 1;

    logic         adv;
    logic [LC+1:0] r_vld;
    t_core        r_core [LC+1];
    t_core        n_entry;
    t_post        r_post;
    t_post        n_post;
    logic         r_out_valid;
    logic signed [VEL_W-1:0] r_velocity;
    logic signed [15:0]      r_steering;
    logic [RHO_W-1:0]        r_distance;
    logic signed [VEL_W-1:0] n_velocity;
    logic signed [15:0]      n_steering;

    assign adv     = !r_out_valid || !i_stall;
    assign o_q_pop = adv && !i_q_empty;

    always_comb begin
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [33:0]       px;
        logic signed [33:0]       py;
        logic signed [CW-1:0]     ex;
        logic signed [CW-1:0]     ey;
        dx = $signed(i_q_item.dx);
        dy = $signed(i_q_item.dy);
        px = dx * dx;
        py = dy * dy;
        ex = CW'(dx) <<< 8;
        ey = CW'(dy) <<< 8;
        n_entry         = '0;
        n_entry.sqx     = px[SQW-1:0];
        n_entry.sqy     = py[SQW-1:0];
        n_entry.cx      = i_q_item.flip ? -ex : ex;
        n_entry.cy      = i_q_item.flip ? -ey : ey;
        n_entry.z       = i_q_item.flip ? HALF_TURN : '0;
        n_entry.ph      = i_q_item.ph;
        n_entry.at_goal = i_q_item.at_goal;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_core[0] <= n_entry;
        end
    end

    for (genvar s = 1; s <= LC; s++) begin : g_stage
        t_core n_mid;
        t_core n_core;
        if (s == 1) begin : g_sum
            always_comb begin
                n_mid      = r_core[s-1];
                n_mid.rem  = NW'(r_core[s-1].sqx) + NW'(r_core[s-1].sqy);
                n_mid.root = '0;
            end
        end else if (s - 2 < SQ_STEPS) begin : g_sqrt
            assign n_mid = sqrt_step(r_core[s-1], 5'(s - 2));
        end else begin : g_sq_hold
            assign n_mid = r_core[s-1];
        end
        if (s - 1 < SE) begin : g_cordic
            assign n_core = cordic_step(n_mid, 5'(s - 1));
        end else begin : g_cd_hold
            assign n_core = n_mid;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_core[s] <= n_core;
            end
        end
    end

    always_comb begin
        logic [31:0]             zr;
        logic [15:0]             bear;
        logic signed [15:0]      alpha;
        logic signed [15:0]      beta;
        logic [RHO_W-1:0]        rho;
        zr    = r_core[LC].z + ROUND_HALF;
        bear  = r_core[LC].at_goal ? 16'd0 : zr[31:16];
        alpha = $signed(bear - r_core[LC].ph);
        beta  = $signed(i_cfg.goal_heading - r_core[LC].ph - alpha);
        rho   = r_core[LC].root[RHO_W-1:0];
        n_post.rho   = rho;
        n_post.vel_p = $signed(i_cfg.gain_distance) * $signed({1'b0, rho});
        n_post.st_a  = $signed(i_cfg.gain_alpha) * alpha;
        n_post.st_b  = $signed(i_cfg.gain_beta) * beta;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_post <= n_post;
        end
    end

    always_comb begin
        logic signed [25:0] vs;
        logic signed [32:0] ss;
        logic signed [24:0] st;
        vs = 26'($signed(r_post.vel_p) >>> 8);
        ss = 33'($signed(r_post.st_a)) + 33'($signed(r_post.st_b));
        st = 25'(ss >>> 8);
        if (vs[25:23] == 3'b000 || vs[25:23] == 3'b111) begin
            n_velocity = vs[VEL_W-1:0];
        end else begin
            n_velocity = vs[25] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end
        if (st[24:15] == '0 || st[24:15] == '1) begin
            n_steering = st[15:0];
        end else begin
            n_steering = st[24] ? 16'sh8000 : 16'sh7FFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_velocity <= n_velocity;
            r_steering <= n_steering;
            r_distance <= r_post.rho;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[LC:0], o_q_pop};
            r_out_valid <= r_vld[LC+1];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_velocity = r_velocity;
    assign o_steering = r_steering;
    assign o_distance = r_distance;

endmodule

>>> sv/polar_pose_controller.sv
// Top level of the polar move-to-pose controller: configuration registers,
// front end, queue and back end. Depends on ppc_pkg, ppc_front, ppc_queue, ppc_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  pose in  | i_valid / o_stall       | i_pose_x, i_pose_y, i_pose_heading
//  command  | o_valid / i_stall       | o_velocity, o_steering, o_distance
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pose beat per cycle, sustained while the command side does not stall.
// Back-end depth follows the longer of the CORDIC chain and 17-step root extraction.
// Synchronous active-low reset clears the queue and stage valids, presets gains/goal.
// A stall on the command side holds the whole back end; the queue absorbs up
// to four beats before o_stall rises.
module polar_pose_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [15:0]           i_pose_x,
    input  logic signed [15:0]           i_pose_y,
    input  logic signed [15:0]           i_pose_heading,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [23:0]           o_velocity,
    output logic signed [15:0]           o_steering,
    output logic [16:0]                  o_distance,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ppc_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [15:0]                  i_cfg_data
);
    import ppc_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_GAIN_DISTANCE: r_cfg.gain_distance <= i_cfg_data;
                REG_GAIN_ALPHA:    r_cfg.gain_alpha    <= i_cfg_data;
                REG_GAIN_BETA:     r_cfg.gain_beta     <= i_cfg_data;
                REG_GOAL_X:        r_cfg.goal_x        <= i_cfg_data;
                REG_GOAL_Y:        r_cfg.goal_y        <= i_cfg_data;
                REG_GOAL_HEADING:  r_cfg.goal_heading  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppc_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pose_x       (i_pose_x),
        .i_pose_y       (i_pose_y),
        .i_pose_heading (i_pose_heading),
        .i_cfg          (r_cfg),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    ppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    ppc_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_item   (q_item),
        .o_q_pop    (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_velocity (o_velocity),
        .o_steering (o_steering),
        .o_distance (o_distance)
    );

endmodule

>>> sv/ppc_checker.sv
// Port-level checks for the polar pose controller, bound to the top level.
// Depends only on the top-level port names.
module ppc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [23:0] o_velocity,
    input logic signed [15:0] o_steering,
    input logic [16:0]        o_distance
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset left a command valid or the input stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_velocity) && $stable(o_steering)
            && $stable(o_distance))
        else $error("stalled command beat changed");

    a_rho_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance <= 17'd92682)
        else $error("distance beyond reachable range");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_distance == 17'd0 |-> o_velocity == 24'sd0)
        else $error("velocity nonzero at zero distance");

endmodule

bind polar_pose_controller ppc_checker u_ppc_checker (.*);

>>> tb/polar_pose_controller_tb.sv
// Self-checking testbench for polar_pose_controller: a directed table of poses and
// register writes, then random phases under varied idling, each command checked
// against typed values or a bit-exact predictor. Depends on ppc_pkg and the RTL.
module polar_pose_controller_tb;
    import ppc_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY      = ((CORDIC_STEPS > 18) ? CORDIC_STEPS : 18) + 3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 14;
    localparam int PHASE_BEATS  = 68;

    localparam logic [CFG_AW-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_AW-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic ROW_POSE  = 1'b0;
    localparam logic ROW_CFG   = 1'b1;
    localparam logic PREDICTED = 1'b0;
    localparam logic TYPED     = 1'b1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [23:0] velocity;
        logic [15:0] steering;
        logic [16:0] distance;
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [CFG_AW-1:0] idx;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [15:0]       ph;
        logic              typed;
        t_cmd              want;
    } t_row;

    localparam int DIR_ROWS = 32;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{ROW_POSE, '0, 16'h0000, 16'h0000, 16'h0000, TYPED, '{24'h0, 16'h0000, 17'h0}},
        '{ROW_POSE, '0, 16'h0000, 16'h0000, 16'h03E8, TYPED, '{24'h0, 16'hEA84, 17'h0}},
        '{ROW_POSE, '0, 16'h0000, 16'h0000, 16'h8000, TYPED, '{24'h0, 16'h8000, 17'h0}},
        '{ROW_POSE, '0, 16'h0000, 16'h0000, 16'h7FFF, TYPED, '{24'h0, 16'h8000, 17'h0}},
        '{ROW_POSE, '0, 16'hFF00, 16'h0000, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h0000, 16'hFF00, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h0100, 16'h0000, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h0000, 16'h0100, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h8000, 16'h8000, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h7FFF, 16'h7FFF, 16'h8000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h7FFF, 16'h8000, 16'h3039, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h8000, 16'h7FFF, 16'hFFFF, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h0001, 16'h0000, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h0000, 16'h0001, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h0000, 16'hFFFF, 16'h0000, PREDICTED, '0},
        '{ROW_CFG, REG_GAIN_DISTANCE, 16'h7FFF, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GAIN_ALPHA,    16'h8000, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GAIN_BETA,     16'h7FFF, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GOAL_X,        16'h7FFF, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GOAL_Y,        16'h8000, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GOAL_HEADING,  16'h8000, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_UNUSED_6,      16'h1234, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_UNUSED_7,      16'hFFFF, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h8000, 16'h7FFF, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h7FFF, 16'h8000, 16'h0000, TYPED, '{24'h0, 16'h8000, 17'h0}},
        '{ROW_POSE, '0, 16'h7FFF, 16'h8000, 16'h4000, TYPED, '{24'h0, 16'h8000, 17'h0}},
        '{ROW_POSE, '0, 16'h7FFF, 16'h7FFF, 16'h8000, PREDICTED, '0},
        '{ROW_CFG, REG_GAIN_DISTANCE, 16'h8000, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GAIN_ALPHA,    16'h7FFF, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_CFG, REG_GAIN_BETA,     16'h8000, 16'h0, 16'h0, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h8000, 16'h7FFF, 16'h0000, PREDICTED, '0},
        '{ROW_POSE, '0, 16'h7FFF, 16'h8000, 16'h0064, TYPED, '{24'h0, 16'h7FFF, 17'h0}}
    };

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic signed [15:0]  i_pose_x       = '0;
    logic signed [15:0]  i_pose_y       = '0;
    logic signed [15:0]  i_pose_heading = '0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic signed [23:0]  o_velocity;
    logic signed [15:0]  o_steering;
    logic [16:0]         o_distance;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_AW-1:0]   i_cfg_index    = '0;
    logic [15:0]         i_cfg_data     = '0;

    t_cfg  cfg_model;
    t_cmd  pending_cmds [$];
    t_cmd  got_cmd;
    t_cmd  want_cmd;
    t_idle idle_mode  = IDLE_NONE;
    int    mismatches = 0;

    polar_pose_controller #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pose_x       (i_pose_x),
        .i_pose_y       (i_pose_y),
        .i_pose_heading (i_pose_heading),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_velocity     (o_velocity),
        .o_steering     (o_steering),
        .o_distance     (o_distance),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_cmd predict_command(t_cfg c, logic [15:0] px, logic [15:0] py,
                                             logic [15:0] ph);
        longint      dx, dy, cx, cy, sx, sy, rem, root, bitv, prod;
        logic [31:0] z;
        logic [31:0] zr;
        logic [15:0] alpha;
        logic [15:0] beta;
        int          steps;
        t_cmd        r;
        dx = longint'($signed(c.goal_x)) - longint'($signed(px));
        dy = longint'($signed(c.goal_y)) - longint'($signed(py));
        rem  = dx * dx + dy * dy;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        zr = '0;
        if (dx != 0 || dy != 0) begin
            cx = dx * 256;
            cy = dy * 256;
            z  = '0;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z  = HALF_TURN;
            end
            steps = (CORDIC_STEPS > ANGLE_LEN) ? ANGLE_LEN : CORDIC_STEPS;
            for (int i = 0; i < steps; i++) begin
                sx = cx >>> i;
                sy = cy >>> i;
                if (cy > 0) begin
                    cx = cx + sy;
                    cy = cy - sx;
                    z  = z + ATAN_LUT[i];
                end else begin
                    cx = cx - sy;
                    cy = cy + sx;
                    z  = z - ATAN_LUT[i];
                end
            end
            zr = z + ROUND_HALF;
        end
        alpha = zr[31:16] - ph;
        beta  = c.goal_heading - ph - alpha;
        prod  = (longint'($signed(c.gain_distance)) * root) >>> 8;
        prod  = clamp(prod, -8388608, 8388607);
        r.velocity = prod[23:0];
        prod  = (longint'($signed(c.gain_alpha)) * longint'($signed(alpha))
                 + longint'($signed(c.gain_beta)) * longint'($signed(beta))) >>> 8;
        prod  = clamp(prod, -32768, 32767);
        r.steering = prod[15:0];
        r.distance = root[16:0];
        return r;
    endfunction

    function automatic bit sender_gap();
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 56 : ((idle_mode == IDLE_BOTH) ? 16 : 0);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_reg_value();
        case ($urandom_range(0, 5))
            0, 1:    return pick_extreme();
            2:       return 16'($urandom_range(0, 1024)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] near(logic [15:0] centre);
        return centre + 16'($urandom_range(0, 6)) - 16'd3;
    endfunction

    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_stall <= ($urandom_range(0, 99) < 56);
            IDLE_BOTH:     i_stall <= ($urandom_range(0, 99) < 16);
            default:       i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_cmd = '{o_velocity, o_steering, o_distance};
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command vel %0d steer %0d dist %0d", $time,
                         $signed(got_cmd.velocity), $signed(got_cmd.steering),
                         got_cmd.distance);
                mismatches++;
            end else begin
                want_cmd = pending_cmds.pop_front();
                if (got_cmd.velocity !== want_cmd.velocity) begin
                    $display("%0t: velocity expected %0d got %0d", $time,
                             $signed(want_cmd.velocity), $signed(got_cmd.velocity));
                    mismatches++;
                end
                if (got_cmd.steering !== want_cmd.steering) begin
                    $display("%0t: steering expected %0d got %0d", $time,
                             $signed(want_cmd.steering), $signed(got_cmd.steering));
                    mismatches++;
                end
                if (got_cmd.distance !== want_cmd.distance) begin
                    $display("%0t: distance expected %0d got %0d", $time,
                             want_cmd.distance, got_cmd.distance);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] ph);
        while (sender_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pose_x       <= px;
        i_pose_y       <= py;
        i_pose_heading <= ph;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GAIN_DISTANCE: cfg_model.gain_distance = data;
            REG_GAIN_ALPHA:    cfg_model.gain_alpha    = data;
            REG_GAIN_BETA:     cfg_model.gain_beta     = data;
            REG_GOAL_X:        cfg_model.goal_x        = data;
            REG_GOAL_Y:        cfg_model.goal_y        = data;
            REG_GOAL_HEADING:  cfg_model.goal_heading  = data;
            default: ;
        endcase
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [15:0] px, py, ph;
        bit          in_cfg;
        t_row        row;
        cfg_model = CFG_RESET;
        in_cfg    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                if (!in_cfg) settle();
                in_cfg = 1'b1;
                write_reg(row.idx, row.px);
            end else begin
                if (in_cfg) i_cfg_valid <= 1'b0;
                in_cfg = 1'b0;
                send_pose(row.px, row.py, row.ph);
                pending_cmds.push_back(row.typed == TYPED ? row.want
                                       : predict_command(cfg_model, row.px, row.py, row.ph));
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            for (int k = 0; k < 6; k++) begin
                write_reg(CFG_AW'(k), (phase == 1) ? 16'h7FFF :
                                      (phase == 2) ? 16'h8000 : rand_reg_value());
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 16'($urandom));
            i_cfg_valid <= 1'b0;
            idle_mode = t_idle'(phase % 4);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (phase == 5 && n == PHASE_BEATS / 2) settle();
                case ($urandom_range(0, 9))
                    0, 1: begin
                        px = near(cfg_model.goal_x);
                        py = near(cfg_model.goal_y);
                    end
                    2: begin
                        px = pick_extreme();
                        py = pick_extreme();
                    end
                    default: begin
                        px = 16'($urandom);
                        py = 16'($urandom);
                    end
                endcase
                case ($urandom_range(0, 5))
                    0:       ph = near(cfg_model.goal_heading);
                    1:       ph = pick_extreme();
                    default: ph = 16'($urandom);
                endcase
                send_pose(px, py, ph);
                pending_cmds.push_back(predict_command(cfg_model, px, py, ph));
            end
        end

        settle();
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
sv/ppc_pkg.sv
sv/ppc_front.sv
sv/ppc_queue.sv
sv/ppc_back.sv
sv/polar_pose_controller.sv
sv/ppc_checker.sv
tb/polar_pose_controller_tb.sv
